FILE: sv/lcdw_pkg.sv
// Package for the character-LCD nibble writer.
// Holds the shared types, register indexes and constants; no dependencies.
package lcdw_pkg;

   localparam int unsigned DELAY_SCALE   = 4000;
   localparam int unsigned PULSE_W       = 20;
   localparam int unsigned LINE_W        = 7;
   localparam int unsigned CSR_INDEX_W   = 2;
   localparam int unsigned QUEUE_DEPTH   = 2;

   localparam logic [PULSE_W-1:0] PULSE_RESET = PULSE_W'(10 * DELAY_SCALE);
   localparam logic [LINE_W-1:0]  LINE_RESET  = LINE_W'(16);

   localparam logic [7:0] LINE2_CMD = 8'hC0;
   localparam logic [7:0] LINE1_CMD = 8'h80;

   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_WIDTH = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_LENGTH = CSR_INDEX_W'(1);

   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       register_select;
      logic       has_line_cmd;
      logic       line1_sel;
   } lcdw_entry_type;

   typedef struct packed {
      logic               wr_pulse;
      logic               wr_line;
      logic [PULSE_W-1:0] data;
   } lcdw_csr_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_STROBE,
      S_SHOW
   } lcdw_state_type;

endpackage

FILE: sv/lcdw_front.sv
// Front end of the LCD writer: accepts items, tracks the column count.
// Classifies each item into a queue entry; depends on lcdw_pkg.
module lcdw_front (
   input  logic                   clock,
   input  logic                   reset,
   input  lcdw_pkg::lcdw_csr_type csr,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   q_full,
   output logic                   q_push,
   output lcdw_pkg::lcdw_entry_type q_entry
);
   import lcdw_pkg::*;

   logic [LINE_W-1:0] count_ff, count_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [LINE_W-1:0] base;
   logic [LINE_W-1:0] next_count;
   logic              is_data;
   logic              hit_line2;
   logic              hit_line1;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;
   assign is_data    = req_tuser[0];

   always_comb begin
      base       = req_tuser[1] ? '0 : count_ff;
      next_count = base + LINE_W'(1);
      hit_line2  = (next_count == line_ff);
      hit_line1  = !hit_line2 && ((next_count == '0) ||
                   ({1'b0, next_count} >= {line_ff, 1'b0}));
   end

   always_comb begin
      q_entry.byte_value      = req_tdata;
      q_entry.register_select = is_data ? RS_DATA : RS_COMMAND;
      q_entry.has_line_cmd    = is_data && (hit_line2 || hit_line1);
      q_entry.line1_sel       = hit_line1;
   end

   always_comb begin
      count_in = count_ff;
      if (q_push && is_data) begin
         count_in = hit_line1 ? '0 : next_count;
      end
      line_in = csr.wr_line ? csr.data[LINE_W-1:0] : line_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         line_ff  <= LINE_RESET;
      end else begin
         count_ff <= count_in;
         line_ff  <= line_in;
      end
   end

endmodule

FILE: sv/lcdw_queue.sv
// Small queue between the front and back ends of the LCD writer.
// Register-based ring of entries; depends on lcdw_pkg.
module lcdw_queue #(
   parameter int unsigned DEPTH = lcdw_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  lcdw_pkg::lcdw_entry_type push_entry,
   input  logic                     pop,
   output lcdw_pkg::lcdw_entry_type pop_entry,
   output logic                     full,
   output logic                     empty
);
   import lcdw_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   lcdw_entry_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == DEPTH_CNT);
   assign empty     = (count_ff == '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue push while full");
   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue pop while empty");
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT) else $error("queue count out of range");
`endif

endmodule

FILE: sv/lcdw_back.sv
// Back end of the LCD writer: times each enable strobe and issues nibbles.
// Pops queue entries and splits them into two or four words; depends on lcdw_pkg.
module lcdw_back (
   input  logic                     clock,
   input  logic                     reset,
   input  lcdw_pkg::lcdw_csr_type   csr,
   input  logic                     q_empty,
   output logic                     q_pop,
   input  lcdw_pkg::lcdw_entry_type q_entry,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic [0:0]               rsp_tuser,
   output logic                     rsp_tlast
);
   import lcdw_pkg::*;

   lcdw_state_type     state_ff, state_in;
   lcdw_entry_type     entry_ff, entry_in;
   logic [1:0]         idx_ff, idx_in;
   logic [PULSE_W-1:0] cnt_ff, cnt_in;
   logic [PULSE_W-1:0] pulse_ff, pulse_in;
   logic               strobe_done;
   logic               is_last;
   logic               load;
   logic               advance;
   logic [7:0]         cur_byte;

   assign strobe_done = ({1'b0, cnt_ff} + (PULSE_W + 1)'(1)) >= {1'b0, pulse_ff};
   assign is_last     = (idx_ff == 2'd3) || ((idx_ff == 2'd1) && !entry_ff.has_line_cmd);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) state_in = S_STROBE;
         end
         S_STROBE: begin
            if (strobe_done) state_in = S_SHOW;
         end
         S_SHOW: begin
            if (rsp_tready) state_in = is_last ? S_IDLE : S_STROBE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      q_pop      = 1'b0;
      rsp_tvalid = 1'b0;
      load       = 1'b0;
      advance    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            q_pop = !q_empty;
            load  = !q_empty;
         end
         S_STROBE: ;
         S_SHOW: begin
            rsp_tvalid = 1'b1;
            advance    = rsp_tready && !is_last;
         end
         default: ;
      endcase
   end

   always_comb begin
      entry_in = load ? q_entry : entry_ff;
      idx_in   = load ? 2'd0 : (advance ? idx_ff + 2'd1 : idx_ff);
      cnt_in   = (load || advance) ? '0 :
                 ((state_ff == S_STROBE) ? cnt_ff + PULSE_W'(1) : cnt_ff);
      pulse_in = csr.wr_pulse ? csr.data : pulse_ff;
   end

   always_comb begin
      cur_byte     = idx_ff[1] ? (entry_ff.line1_sel ? LINE1_CMD : LINE2_CMD)
                               : entry_ff.byte_value;
      rsp_tdata    = {4'b0000, (idx_ff[0] ? cur_byte[3:0] : cur_byte[7:4])};
      rsp_tuser[0] = idx_ff[1] ? RS_COMMAND : entry_ff.register_select;
      rsp_tlast    = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         pulse_ff <= PULSE_RESET;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         pulse_ff <= pulse_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

`ifndef SYNTHESIS
   a_last_ends_item : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> state_ff == S_IDLE)
      else $error("back end did not return to idle after last word");
   a_line_word_needs_cmd : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && idx_ff[1] |-> entry_ff.has_line_cmd)
      else $error("line command word issued without a line command");
`endif

endmodule

FILE: sv/char_lcd_nibble_writer_top.sv
// Character-LCD nibble writer, 4-bit interface, top level.
// Instantiates lcdw_front, lcdw_queue and lcdw_back; depends on lcdw_pkg.
//
// Usage:
//   req_* channel: one word per byte to write. tdata[7:0] is the byte;
//   tuser[0] is 1 for a data character, 0 for a command; tuser[1] clears
//   the column count before a data character.
//   rsp_* channel: one word per nibble strobe. tdata[3:0] is the nibble
//   (high nibble first), tuser[0] is register select, tlast marks the
//   final nibble of a byte. A data byte that ends a line is followed by
//   the line command 0xC0 or 0x80, which gives four words instead of two.
//   csr_* channel: index 0 sets the strobe width in cycles, index 1 the
//   line length; write only while idle.
// Flow: before each nibble the back-end strobe counter runs for the
//   strobe width P, then the nibble is held until the receiver takes
//   it; a new byte is popped only after the last nibble of the one
//   before. Input words are queued (default depth two) while the back
//   end works, so req_tready only drops when the queue is full.
// Reset: synchronous, clears the column count, empties the queue, and
//   restores strobe width 40000 and line length 16. A stalled receiver
//   holds the current nibble until taken.
module char_lcd_nibble_writer_top #(
   parameter int unsigned QUEUE_DEPTH = lcdw_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // byte_value
   input  logic [1:0]                           req_tuser,  // req_type, string_start
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,  // nibble, zero pad
   output logic [0:0]                           rsp_tuser,  // register_select
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lcdw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lcdw_pkg::PULSE_W-1:0]         csr_data
);
   import lcdw_pkg::*;

   lcdw_csr_type   csr;
   lcdw_entry_type push_entry;
   lcdw_entry_type pop_entry;
   logic           q_push;
   logic           q_pop;
   logic           q_full;
   logic           q_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      csr.wr_pulse = csr_valid && (csr_index == CSR_PULSE_WIDTH);
      csr.wr_line  = csr_valid && (csr_index == CSR_LINE_LENGTH);
      csr.data     = csr_data;
   end

   lcdw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   lcdw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   lcdw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .q_entry    (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
